// File: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define UBFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define UBFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/ubfp_pkg.sv
`default_nettype none
package ubfp_pkg;

  localparam int FRAME_BYTES_DEF = 32;
  localparam int HDR_BYTES       = 4;

  // flash layout
  localparam int SEG_FIRST = 'hC000;
  localparam int SEG_END   = 'hFBFF;
  localparam int SEG_STEP  = 'h200;
  localparam int SEG_COUNT = (SEG_END - SEG_FIRST + SEG_STEP - 1) / SEG_STEP;
  localparam int SEG_W     = $clog2(SEG_COUNT);
  localparam logic [15:0] APP_ENTRY = 16'hC000;

  // input operations
  localparam logic OP_BYTE   = 1'b0;
  localparam logic OP_WINDOW = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_ERASE = 2'd1;
  localparam logic [1:0] KIND_REPLY = 2'd2;
  localparam logic [1:0] KIND_START = 2'd3;

  // characters
  localparam logic [7:0] CH_BOOT     = 8'h62;  // 'b'
  localparam logic [7:0] CH_PLUS     = 8'h2B;  // '+'
  localparam logic [7:0] CH_MINUS    = 8'h2D;  // '-'
  localparam logic [7:0] CH_PROMPT   = 8'h3E;  // '>'
  localparam logic [7:0] CH_FAIL     = 8'h21;  // '!'
  localparam logic [7:0] ERASED_BYTE = 8'hFF;

  typedef enum logic [2:0] {
    JOB_START,
    JOB_ERASE,
    JOB_ERASE_REPLY,
    JOB_BAD_LEN,
    JOB_WRITE
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [15:0] base;
    logic [7:0]  len;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ERASE,
    B_RD,
    B_WR,
    B_REPLY
  } back_state_t;

endpackage
`default_nettype wire

// File: rtl/ubfp_ram.sv
`default_nettype none
module ubfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/ubfp_front.sv
`default_nettype none
module ubfp_front #(
  parameter int FRAME_BYTES = ubfp_pkg::FRAME_BYTES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_operation,
  input  wire logic [7:0]                     in_rx_byte,
  input  wire logic                           q_full,
  output logic                                q_push,
  output ubfp_pkg::job_t                      q_job,
  input  wire logic                           write_done,
  output logic                                ram_we,
  output logic [$clog2(FRAME_BYTES)-1:0]      ram_waddr,
  output logic [7:0]                          ram_wdata
);

  localparam int FILL_W = $clog2(FRAME_BYTES + 1);
  localparam int IDX_W  = $clog2(FRAME_BYTES);
  localparam logic [7:0] MAX_LEN = 8'(FRAME_BYTES - ubfp_pkg::HDR_BYTES);

  logic              boot_sel_r, boot_sel_nxt;
  logic              armed_r, armed_nxt;
  logic              wr_pend_r, wr_pend_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [7:0]        cmd_r, cmd_nxt;
  logic [7:0]        hi_r, hi_nxt;
  logic [7:0]        lo_r, lo_nxt;
  logic [7:0]        len_r, len_nxt;
  logic              accept;
  logic              frame_done;

  // a queued or running write frame owns the buffer until its last read
  assign in_stall = q_full || wr_pend_r;
  assign accept   = in_valid && !in_stall;

  assign frame_done = (9'(fill_r) + 9'd1) == ({1'b0, len_r} + 9'(ubfp_pkg::HDR_BYTES));
  assign ram_waddr  = IDX_W'(fill_r - FILL_W'(ubfp_pkg::HDR_BYTES));
  assign ram_wdata  = in_rx_byte;

  always_comb begin
    boot_sel_nxt = boot_sel_r;
    armed_nxt    = armed_r;
    wr_pend_nxt  = wr_pend_r;
    fill_nxt     = fill_r;
    cmd_nxt      = cmd_r;
    hi_nxt       = hi_r;
    lo_nxt       = lo_r;
    len_nxt      = len_r;
    q_push       = 1'b0;
    q_job.kind   = ubfp_pkg::JOB_START;
    q_job.base   = {hi_r, lo_r};
    q_job.len    = len_r;
    ram_we       = 1'b0;
    if (write_done) begin
      wr_pend_nxt = 1'b0;
    end
    if (accept) begin
      if (in_operation == ubfp_pkg::OP_WINDOW) begin
        if (!armed_r) begin
          q_push = 1'b1;
          if (boot_sel_r) begin
            q_job.kind = ubfp_pkg::JOB_ERASE;
            armed_nxt  = 1'b1;
            fill_nxt   = '0;
          end else begin
            q_job.kind = ubfp_pkg::JOB_START;
          end
        end
      end else if (!boot_sel_r) begin
        if (in_rx_byte == ubfp_pkg::CH_BOOT) begin
          boot_sel_nxt = 1'b1;
        end
      end else if (armed_r) begin
        if (fill_r < FILL_W'(ubfp_pkg::HDR_BYTES)) begin
          fill_nxt = fill_r + FILL_W'(1);
          case (fill_r[1:0])
            2'd0: cmd_nxt = in_rx_byte;
            2'd1: hi_nxt  = in_rx_byte;
            2'd2: lo_nxt  = in_rx_byte;
            default: begin
              len_nxt = in_rx_byte;
              if (in_rx_byte == 8'd0 || in_rx_byte > MAX_LEN) begin
                q_push     = 1'b1;
                q_job.kind = ubfp_pkg::JOB_BAD_LEN;
                fill_nxt   = '0;
              end
            end
          endcase
        end else begin
          ram_we   = 1'b1;
          fill_nxt = fill_r + FILL_W'(1);
          if (frame_done) begin
            fill_nxt = '0;
            if (cmd_r == ubfp_pkg::CH_PLUS) begin
              q_push      = 1'b1;
              q_job.kind  = ubfp_pkg::JOB_WRITE;
              wr_pend_nxt = 1'b1;
            end else if (cmd_r == ubfp_pkg::CH_MINUS) begin
              q_push     = 1'b1;
              q_job.kind = ubfp_pkg::JOB_ERASE_REPLY;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      boot_sel_r <= 1'b0;
      armed_r    <= 1'b0;
      wr_pend_r  <= 1'b0;
      fill_r     <= '0;
    end else begin
      boot_sel_r <= boot_sel_nxt;
      armed_r    <= armed_nxt;
      wr_pend_r  <= wr_pend_nxt;
      fill_r     <= fill_nxt;
    end
    cmd_r <= cmd_nxt;
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
    len_r <= len_nxt;
  end

endmodule
`default_nettype wire

// File: rtl/ubfp_queue.sv
`default_nettype none
module ubfp_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire ubfp_pkg::job_t push_job,
  output logic                full,
  input  wire logic           pop,
  output logic                empty,
  output ubfp_pkg::job_t      head
);

  ubfp_pkg::job_t q_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign head  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      q_r[wr_ptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ubfp_back.sv
`default_nettype none
module ubfp_back #(
  parameter int FRAME_BYTES = ubfp_pkg::FRAME_BYTES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      q_empty,
  input  wire ubfp_pkg::job_t            q_head,
  output logic                           q_pop,
  output logic                           write_done,
  output logic [$clog2(FRAME_BYTES)-1:0] ram_raddr,
  input  wire logic [7:0]                ram_rdata,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [1:0]                     out_kind,
  output logic [15:0]                    out_address,
  output logic [7:0]                     out_value,
  output logic                           out_last
);

  localparam int IDX_W = $clog2(FRAME_BYTES);
  localparam int SEG_W = ubfp_pkg::SEG_W;

  ubfp_pkg::back_state_t state_r, state_nxt;
  logic [SEG_W-1:0] seg_r, seg_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [15:0]      base_r, base_nxt;
  logic [7:0]       len_r, len_nxt;
  logic             rep_r, rep_nxt;
  logic [7:0]       rchar_r, rchar_nxt;

  logic             out_valid_r;
  logic [1:0]       out_kind_r;
  logic [15:0]      out_address_r;
  logic [7:0]       out_value_r;
  logic             out_last_r;

  logic             out_free;
  logic             seg_last;
  logic             idx_last;
  logic             byte_skip;
  logic             emit;
  logic [1:0]       e_kind;
  logic [15:0]      e_addr;
  logic [7:0]       e_val;
  logic             e_last;

  assign out_free  = !out_valid_r || !out_stall;
  assign seg_last  = seg_r == SEG_W'(ubfp_pkg::SEG_COUNT - 1);
  assign idx_last  = (9'(idx_r) + 9'd1) == {1'b0, len_r};
  assign byte_skip = ram_rdata == ubfp_pkg::ERASED_BYTE;
  assign ram_raddr = idx_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ubfp_pkg::B_IDLE: begin
        if (!q_empty && out_free) begin
          case (q_head.kind)
            ubfp_pkg::JOB_ERASE, ubfp_pkg::JOB_ERASE_REPLY: state_nxt = ubfp_pkg::B_ERASE;
            ubfp_pkg::JOB_WRITE: state_nxt = ubfp_pkg::B_RD;
            default: state_nxt = ubfp_pkg::B_IDLE;
          endcase
        end
      end
      ubfp_pkg::B_ERASE: begin
        if (out_free && seg_last) begin
          state_nxt = rep_r ? ubfp_pkg::B_REPLY : ubfp_pkg::B_IDLE;
        end
      end
      ubfp_pkg::B_RD: state_nxt = ubfp_pkg::B_WR;
      ubfp_pkg::B_WR: begin
        if (byte_skip || out_free) begin
          state_nxt = idx_last ? ubfp_pkg::B_REPLY : ubfp_pkg::B_RD;
        end
      end
      ubfp_pkg::B_REPLY: begin
        if (out_free) begin
          state_nxt = ubfp_pkg::B_IDLE;
        end
      end
      default: state_nxt = ubfp_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = 1'b0;
    write_done = 1'b0;
    seg_nxt    = seg_r;
    idx_nxt    = idx_r;
    base_nxt   = base_r;
    len_nxt    = len_r;
    rep_nxt    = rep_r;
    rchar_nxt  = rchar_r;
    emit       = 1'b0;
    e_kind     = ubfp_pkg::KIND_REPLY;
    e_addr     = 16'd0;
    e_val      = 8'd0;
    e_last     = 1'b0;
    case (state_r)
      ubfp_pkg::B_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop = 1'b1;
          case (q_head.kind)
            ubfp_pkg::JOB_START: begin
              emit   = 1'b1;
              e_kind = ubfp_pkg::KIND_START;
              e_addr = ubfp_pkg::APP_ENTRY;
              e_last = 1'b1;
            end
            ubfp_pkg::JOB_BAD_LEN: begin
              emit   = 1'b1;
              e_val  = ubfp_pkg::CH_FAIL;
              e_last = 1'b1;
            end
            ubfp_pkg::JOB_ERASE: begin
              seg_nxt = '0;
              rep_nxt = 1'b0;
            end
            ubfp_pkg::JOB_ERASE_REPLY: begin
              seg_nxt   = '0;
              rep_nxt   = 1'b1;
              rchar_nxt = ubfp_pkg::CH_FAIL;
            end
            ubfp_pkg::JOB_WRITE: begin
              idx_nxt   = '0;
              base_nxt  = q_head.base;
              len_nxt   = q_head.len;
              rchar_nxt = ubfp_pkg::CH_PROMPT;
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      ubfp_pkg::B_ERASE: begin
        if (out_free) begin
          emit    = 1'b1;
          e_kind  = ubfp_pkg::KIND_ERASE;
          e_addr  = 16'(ubfp_pkg::SEG_FIRST + int'(seg_r) * ubfp_pkg::SEG_STEP);
          e_last  = seg_last && !rep_r;
          seg_nxt = seg_r + SEG_W'(1);
        end
      end
      ubfp_pkg::B_WR: begin
        // erased bytes are skipped without waiting on the output
        if (!byte_skip && out_free) begin
          emit   = 1'b1;
          e_kind = ubfp_pkg::KIND_WRITE;
          e_addr = base_r + 16'(idx_r);
          e_val  = ram_rdata;
        end
        if (byte_skip || out_free) begin
          idx_nxt    = idx_r + IDX_W'(1);
          write_done = idx_last;
        end
      end
      ubfp_pkg::B_REPLY: begin
        if (out_free) begin
          emit   = 1'b1;
          e_val  = rchar_r;
          e_last = 1'b1;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ubfp_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_free) begin
        out_valid_r <= emit;
      end
    end
    seg_r   <= seg_nxt;
    idx_r   <= idx_nxt;
    base_r  <= base_nxt;
    len_r   <= len_nxt;
    rep_r   <= rep_nxt;
    rchar_r <= rchar_nxt;
    if (emit) begin
      out_kind_r    <= e_kind;
      out_address_r <= e_addr;
      out_value_r   <= e_val;
      out_last_r    <= e_last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_address = out_address_r;
  assign out_value   = out_value_r;
  assign out_last    = out_last_r;

endmodule
`default_nettype wire

// File: rtl/uart_boot_frame_programmer.sv
`default_nettype none
// Serial boot-frame programmer. Takes received bytes and boot-window events and
// issues flash writes, segment erases, reply bytes and a start-application result,
// with out_last on the final result of each input word. Input words are taken one
// per cycle; the front stalls only while the two-entry job queue is full, or while
// a '+' frame still owns the frame buffer. A start or bad-length reply leaves the
// output register in the cycle after dispatch; an erase job emits its 30 erases at
// one per cycle after dispatch (31 results with the '!' reply); a '+' frame steps
// through a read state and a write state per payload byte (frame buffer read is
// registered), then the reply. Output stalls hold the back end in place.
module uart_boot_frame_programmer #(
  parameter int FRAME_BYTES = ubfp_pkg::FRAME_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_operation,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [15:0]      out_address,
  output logic [7:0]       out_value,
  output logic             out_last
);

  localparam int IDX_W = $clog2(FRAME_BYTES);

  logic             q_push;
  ubfp_pkg::job_t   q_job;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;
  ubfp_pkg::job_t   q_head;
  logic             write_done;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [7:0]       ram_rdata;

  ubfp_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_rx_byte   (in_rx_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (q_job),
    .write_done   (write_done),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata)
  );

  ubfp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  ubfp_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ubfp_back #(.FRAME_BYTES(FRAME_BYTES)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .write_done  (write_done),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_kind    (out_kind),
    .out_address (out_address),
    .out_value   (out_value),
    .out_last    (out_last)
  );

endmodule
`default_nettype wire

// File: rtl/ubfp_checker.sv
`default_nettype none
`include "assert_macros.svh"
module ubfp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        in_operation,
  input wire logic [7:0]  in_rx_byte,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  out_kind,
  input wire logic [15:0] out_address,
  input wire logic [7:0]  out_value,
  input wire logic        out_last
);

  `UBFP_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_valid, "output valid right after reset")

  `UBFP_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_address) && $stable(out_value) && $stable(out_last), "stalled result word changed")

  `UBFP_ASSERT(a_start_word, out_valid && out_kind == ubfp_pkg::KIND_START |-> out_last && out_address == ubfp_pkg::APP_ENTRY && out_value == 8'd0, "bad start word")

  `UBFP_ASSERT(a_reply_word, out_valid && out_kind == ubfp_pkg::KIND_REPLY |-> out_last && out_address == 16'd0 && (out_value == ubfp_pkg::CH_PROMPT || out_value == ubfp_pkg::CH_FAIL), "bad reply word")

  `UBFP_ASSERT(a_erase_word, out_valid && out_kind == ubfp_pkg::KIND_ERASE |-> out_address[8:0] == 9'd0 && out_address[15:14] == 2'b11 && out_value == 8'd0, "bad erase word")

endmodule

bind uart_boot_frame_programmer ubfp_checker u_ubfp_checker (.*);
`default_nettype wire
